/* hdl/assert_macros.svh */
// Assertion macros shared by the checker modules of this project.
// Each macro reports a failed property through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/pgs_pkg.sv */
// Package for the Phong glossy specular block: register indices,
// reset values and fixed-point constants. Depends on nothing.
package pgs_pkg;

   localparam int IDX_W   = 3;
   localparam int COMP_W  = 16;
   localparam int STAGES  = 9;

   localparam logic [IDX_W-1:0] REG_GAIN  = 3'd0;
   localparam logic [IDX_W-1:0] REG_SHINE = 3'd1;
   localparam logic [IDX_W-1:0] REG_RED   = 3'd2;
   localparam logic [IDX_W-1:0] REG_GREEN = 3'd3;
   localparam logic [IDX_W-1:0] REG_BLUE  = 3'd4;

   localparam logic [15:0] GAIN_RST  = 16'hFFFF;
   localparam logic [15:0] SHINE_RST = 16'd2560;
   localparam logic [15:0] COLOUR_RST = 16'hFFFF;

   localparam logic [16:0] ONE_Q16 = 17'h10000;

endpackage

/* hdl/phong_glossy_specular.sv */
// Phong glossy specular term: a nine-stage pipeline from three Q1.14 vectors
// to saturated Q0.16 RGB. Depends on pgs_pkg.
//
// Usage: the req_ channel carries one shading sample per beat (normal,
// light and view vectors). The rsp_ channel returns one beat of red,
// green and blue per sample, in order. The csr_ channel writes the gain,
// exponent and colour registers; it is always ready and should only be
// written while the pipeline is empty.
// The pipeline takes one beat every cycle unless the output stalls. The depth
// is set by the chain of multipliers: component products, the split
// reflection product, the exponent product, the gain product and the colour
// products each have a register after them.
// When the receiver holds rsp_tready low with a result waiting, the whole
// pipeline stalls and req_tready falls in the same cycle; nothing is lost.
// Reset empties the pipeline and loads the register defaults.
module phong_glossy_specular (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // normal_x, normal_y, normal_z, light_x, light_y, light_z, view_x, view_y, view_z
   input  logic [143:0]             req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // out_red, out_green, out_blue
   output logic [47:0]              rsp_tdata,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [pgs_pkg::IDX_W-1:0] csr_index,
   input  logic [15:0]              csr_data
);
   import pgs_pkg::*;

   logic [15:0] gain_ff, shine_ff, red_ff, green_ff, blue_ff;
   logic [STAGES-1:0] vld_ff, vld_in;
   logic advance;

   logic signed [15:0] n [3];
   logic signed [15:0] l [3];
   logic signed [15:0] v [3];
   logic signed [31:0] s1_nl_ff [3], s1_nv_ff [3], s1_lv_ff [3];
   logic signed [31:0] s1_nl_in [3], s1_nv_in [3], s1_lv_in [3];

   logic signed [32:0] s2_a, s2_b_in, s2_lv_in, s2_b_ff, s2_lv_ff;
   logic signed [25:0] s2_a21_in, s2_a21_ff;

   logic signed [41:0] s3_ph_in, s3_ph_ff;
   logic signed [43:0] s3_pl_in, s3_pl_ff;
   logic signed [32:0] s3_lv_ff;

   logic signed [61:0] s4_sum, s4_rv;
   logic        s4_pos_in, s4_pos_ff;
   logic [16:0] s4_x_in, s4_x_ff;

   logic [3:0]  s5_p;
   logic [15:0] s5_m;
   logic [20:0] s5_l_in, s5_l_ff;
   logic        s5_sat_in, s5_sat_ff, s5_zero_in, s5_zero_ff, s5_pos_ff;

   logic [36:0] s6_y_in, s6_y_ff;
   logic        s6_sat_ff, s6_zero_ff, s6_pos_ff;

   logic [12:0] s7_k;
   logic [16:0] s7_mant, s7_pw_in, s7_pw_ff;

   logic [32:0] s8_t_full;
   logic [16:0] s8_t_ff;

   logic [32:0] s9_r, s9_g, s9_b;
   logic [15:0] s9_red_in, s9_green_in, s9_blue_in;
   logic [15:0] s9_red_ff, s9_green_ff, s9_blue_ff;

   assign advance    = !vld_ff[STAGES-1] || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = vld_ff[STAGES-1];
   assign rsp_tdata  = {s9_blue_ff, s9_green_ff, s9_red_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= GAIN_RST;
         shine_ff <= SHINE_RST;
         red_ff   <= COLOUR_RST;
         green_ff <= COLOUR_RST;
         blue_ff  <= COLOUR_RST;
      end else if (csr_valid) begin
         case (csr_index)
            REG_GAIN:  gain_ff  <= csr_data;
            REG_SHINE: shine_ff <= csr_data;
            REG_RED:   red_ff   <= csr_data;
            REG_GREEN: green_ff <= csr_data;
            REG_BLUE:  blue_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign vld_in = {vld_ff[STAGES-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n[i] = $signed(req_tdata[i*COMP_W +: COMP_W]);
         l[i] = $signed(req_tdata[(3+i)*COMP_W +: COMP_W]);
         v[i] = $signed(req_tdata[(6+i)*COMP_W +: COMP_W]);
         s1_nl_in[i] = n[i] * l[i];
         s1_nv_in[i] = n[i] * v[i];
         s1_lv_in[i] = l[i] * v[i];
      end
   end

   assign s2_a = 33'(s1_nl_ff[0]) + 33'(s1_nl_ff[1]) + 33'(s1_nl_ff[2]);
   assign s2_a21_in = s2_a[32:7];
   assign s2_b_in  = 33'(s1_nv_ff[0]) + 33'(s1_nv_ff[1]) + 33'(s1_nv_ff[2]);
   assign s2_lv_in = 33'(s1_lv_ff[0]) + 33'(s1_lv_ff[1]) + 33'(s1_lv_ff[2]);

   assign s3_ph_in = s2_a21_ff * $signed(s2_b_ff[32:17]);
   assign s3_pl_in = s2_a21_ff * $signed({1'b0, s2_b_ff[16:0]});

   always_comb begin
      s4_sum = (62'(s3_ph_ff) <<< 17) + 62'(s3_pl_ff);
      s4_rv  = (s4_sum <<< 1) - (62'(s3_lv_ff) <<< 21);
      s4_pos_in = !s4_rv[61] && (s4_rv != '0);
      if (|s4_rv[60:49]) begin
         s4_x_in = ONE_Q16;
      end else begin
         s4_x_in = {1'b0, s4_rv[48:33]};
      end
   end

   always_comb begin
      s5_p = '0;
      for (int i = 0; i < 16; i++) begin
         if (s4_x_ff[i]) begin
            s5_p = 4'(i);
         end
      end
      s5_m = s4_x_ff[15:0] << (4'd15 - s5_p);
      s5_l_in = ((21'd16 - 21'(s5_p)) << 16) - (21'(s5_m - 16'h8000) << 1);
      s5_sat_in  = (shine_ff == '0) || s4_x_ff[16];
      s5_zero_in = (s4_x_ff == '0);
   end

   assign s6_y_in = 37'(s5_l_ff) * 37'(shine_ff);

   always_comb begin
      s7_k    = s6_y_ff[36:24];
      s7_mant = ONE_Q16 - 17'(s6_y_ff[23:9]);
      if (!s6_pos_ff) begin
         s7_pw_in = '0;
      end else if (s6_sat_ff) begin
         s7_pw_in = ONE_Q16;
      end else if (s6_zero_ff || (s7_k > 13'd16)) begin
         s7_pw_in = '0;
      end else begin
         s7_pw_in = s7_mant >> s7_k[4:0];
      end
   end

   assign s8_t_full = 33'(s7_pw_ff) * 33'(gain_ff);

   always_comb begin
      s9_r = 33'(s8_t_ff) * 33'(red_ff);
      s9_g = 33'(s8_t_ff) * 33'(green_ff);
      s9_b = 33'(s8_t_ff) * 33'(blue_ff);
      s9_red_in   = s9_r[32] ? 16'hFFFF : s9_r[31:16];
      s9_green_in = s9_g[32] ? 16'hFFFF : s9_g[31:16];
      s9_blue_in  = s9_b[32] ? 16'hFFFF : s9_b[31:16];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_nl_ff   <= s1_nl_in;
         s1_nv_ff   <= s1_nv_in;
         s1_lv_ff   <= s1_lv_in;
         s2_a21_ff  <= s2_a21_in;
         s2_b_ff    <= s2_b_in;
         s2_lv_ff   <= s2_lv_in;
         s3_ph_ff   <= s3_ph_in;
         s3_pl_ff   <= s3_pl_in;
         s3_lv_ff   <= s2_lv_ff;
         s4_pos_ff  <= s4_pos_in;
         s4_x_ff    <= s4_x_in;
         s5_l_ff    <= s5_l_in;
         s5_sat_ff  <= s5_sat_in;
         s5_zero_ff <= s5_zero_in;
         s5_pos_ff  <= s4_pos_ff;
         s6_y_ff    <= s6_y_in;
         s6_sat_ff  <= s5_sat_ff;
         s6_zero_ff <= s5_zero_ff;
         s6_pos_ff  <= s5_pos_ff;
         s7_pw_ff   <= s7_pw_in;
         s8_t_ff    <= s8_t_full[32:16];
         s9_red_ff  <= s9_red_in;
         s9_green_ff <= s9_green_in;
         s9_blue_ff <= s9_blue_in;
      end
   end

endmodule

/* hdl/pgs_checker.sv */
// Port-level checks for phong_glossy_specular, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module pgs_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [47:0]               rsp_tdata
);

   `ASSERT_CLKD(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp beat dropped while stalled")
   `ASSERT_CLKD(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "rsp beat changed while stalled")
   `ASSERT_CLKD(a_stall_back, clock, reset, rsp_tvalid && !rsp_tready |-> !req_tready, "req beat taken while output stalled")
   `ASSERT_CLKD(a_empty_ready, clock, reset, !rsp_tvalid |-> req_tready, "req not ready with output empty")
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "rsp beat just after reset")

endmodule

bind phong_glossy_specular pgs_checker u_pgs_checker (.*);

/* verif/tb_phong_glossy_specular.sv */
// Self-checking testbench for phong_glossy_specular: drives shading samples,
// predicts each RGB beat in a scoreboard class and compares in order.
// Depends on pgs_pkg and the phong_glossy_specular RTL.
module tb_phong_glossy_specular;
   import pgs_pkg::*;

   typedef struct packed {
      logic [15:0] blue;
      logic [15:0] green;
      logic [15:0] red;
   } rgb_type;

   class specular_scoreboard;
      logic [15:0] gain, shine, red, green, blue;
      rgb_type pending[$];
      int errors;

      function new();
         gain = GAIN_RST;
         shine = SHINE_RST;
         red = COLOUR_RST;
         green = COLOUR_RST;
         blue = COLOUR_RST;
         errors = 0;
      endfunction

      function void write_reg(logic [IDX_W-1:0] idx, logic [15:0] val);
         case (idx)
            REG_GAIN: gain = val;
            REG_SHINE: shine = val;
            REG_RED: red = val;
            REG_GREEN: green = val;
            REG_BLUE: blue = val;
            default: ;
         endcase
      endfunction

      function logic [16:0] raise_power(logic [16:0] x);
         int p;
         logic [63:0] m, lg, y, k, f;
         if (shine == 0 || x >= ONE_Q16) return ONE_Q16;
         if (x == 0) return 0;
         p = 15;
         while (p > 0 && x[p] == 1'b0) p--;
         m = 64'(x) << (15 - p);
         lg = (64'(16 - p) << 16) - ((m - 64'd32768) << 1);
         y = lg * 64'(shine);
         k = y >> 24;
         f = y & 64'hFFFFFF;
         if (k > 16) return 0;
         return 17'((64'd65536 - (f >> 9)) >> k);
      endfunction

      function logic [15:0] scale_channel(logic [63:0] t, logic [15:0] c);
         logic [63:0] v;
         v = (t * 64'(c)) >> 16;
         return v > 65535 ? 16'hFFFF : v[15:0];
      endfunction

      function void note_sample(logic [143:0] d);
         longint n[3], l[3], v[3];
         longint a, b, lv, a21, rv, xs;
         logic [63:0] t;
         rgb_type r;
         a = 0; b = 0; lv = 0;
         for (int i = 0; i < 3; i++) begin
            n[i] = $signed(d[16*i +: 16]);
            l[i] = $signed(d[16*(i+3) +: 16]);
            v[i] = $signed(d[16*(i+6) +: 16]);
         end
         for (int i = 0; i < 3; i++) begin
            a += n[i] * l[i];
            b += n[i] * v[i];
            lv += l[i] * v[i];
         end
         a21 = a >>> 7;
         rv = 2 * a21 * b - lv * (longint'(1) << 21);
         r = '0;
         if (rv > 0) begin
            xs = rv >>> 33;
            t = (64'(raise_power(xs > 65536 ? 17'h10000 : 17'(xs))) * 64'(gain)) >> 16;
            r.red = scale_channel(t, red);
            r.green = scale_channel(t, green);
            r.blue = scale_channel(t, blue);
         end
         pending.push_back(r);
      endfunction

      task check_result(logic [47:0] d);
         rgb_type e, g;
         g = d;
         if (pending.size() == 0) begin
            report("result beat with nothing expected");
            return;
         end
         e = pending.pop_front();
         if (g.red !== e.red) report($sformatf("red %0d, expected %0d", g.red, e.red));
         if (g.green !== e.green)
            report($sformatf("green %0d, expected %0d", g.green, e.green));
         if (g.blue !== e.blue) report($sformatf("blue %0d, expected %0d", g.blue, e.blue));
      endtask

      task report(string s);
         $display("MISMATCH: %s", s);
         errors++;
      endtask
   endclass

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tready;
   logic [143:0] req_tdata = '0;
   logic rsp_tvalid, rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic csr_valid = 0, csr_ready;
   logic [IDX_W-1:0] csr_index = '0;
   logic [15:0] csr_data = '0;
   specular_scoreboard sb = new();
   bit calm = 0;
   int cycles = 0;

   phong_glossy_specular u_dut (.*);

   initial forever #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver: accept beats and stall in random bursts.
   initial begin
      int gap;
      rsp_tready <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         rsp_tready <= 1'b1;
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (!calm && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 13);
            rsp_tready <= 1'b0;
            repeat (gap) begin
               @(posedge clock);
            end
         end
      end
   end

   task automatic send_sample(logic [143:0] d);
      req_tvalid <= 1'b1;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_sample(d);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (STAGES + 4) @(posedge clock);
   endtask

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   function automatic logic [143:0] pack(int nv[3], int lv[3], int vv[3]);
      logic [143:0] d;
      for (int i = 0; i < 3; i++) begin
         d[16*i +: 16] = 16'(nv[i]);
         d[16*(i+3) +: 16] = 16'(lv[i]);
         d[16*(i+6) +: 16] = 16'(vv[i]);
      end
      return d;
   endfunction

   // Roughly unit vectors near base directions, Q1.14.
   function automatic logic [143:0] shaped_sample();
      int nv[3], lv[3], vv[3];
      int j;
      for (int i = 0; i < 3; i++) begin
         nv[i] = $urandom_range(0, 2000) - 1000;
         lv[i] = $urandom_range(0, 4000) - 2000;
         vv[i] = $urandom_range(0, 4000) - 2000;
      end
      nv[2] = 16384;
      lv[2] = 16000;
      j = $urandom_range(0, 3);
      vv[2] = 16000 - j * 4000;
      vv[0] += j * 3000;
      return pack(nv, lv, vv);
   endfunction

   task automatic set_all(logic [15:0] g, logic [15:0] e, logic [15:0] r,
                          logic [15:0] gr, logic [15:0] b);
      write_reg(REG_GAIN, g);
      write_reg(REG_SHINE, e);
      write_reg(REG_RED, r);
      write_reg(REG_GREEN, gr);
      write_reg(REG_BLUE, b);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int z[3] = '{0, 0, 0};
      int up[3] = '{0, 0, 16384};
      int tilt[3] = '{2000, 0, 16200};
      int far[3] = '{16000, 0, 3000};
      int mx[3] = '{32767, 32767, 32767};
      int mn[3] = '{-32768, -32768, -32768};
      logic [15:0] e;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Reset settings, then directed cases: full dot, not positive, tiny dot,
      // extremes and non-unit vectors.
      send_sample(pack(up, up, up));
      send_sample(pack(up, up, tilt));
      send_sample(pack(up, up, far));
      send_sample(pack(up, mn, up));
      send_sample(pack(z, up, up));
      send_sample(pack(mx, mx, mx));
      send_sample(pack(mn, mn, mn));
      send_sample(pack(mx, mn, mx));
      send_sample(pack(up, '{1, 0, 1}, '{0, 1, 1}));
      send_sample('1);
      send_sample('0);
      drain();
      set_all(16'h8000, 16'd0, 16'h4000, 16'hFFFF, 16'd0);
      send_sample(pack(up, up, far));
      send_sample(pack(up, '{1, 0, 1}, '{0, 1, 1}));
      send_sample(pack(up, up, '{-16384, 0, 0}));
      drain();
      set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'h1234);
      send_sample(pack(up, up, tilt));
      send_sample(pack(up, up, far));
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         e = (ph == 0) ? 16'd256 : (ph == 1) ? 16'd1 : 16'($urandom_range(0, 16384));
         set_all(16'($urandom), e, 16'($urandom), 16'($urandom), 16'($urandom));
         if (ph == 5) calm = 1;
         for (int i = 0; i < 155; i++) begin
            if ($urandom_range(0, 4) == 0) send_sample(144'({$urandom, $urandom, $urandom,
                                                             $urandom, $urandom}));
            else send_sample(shaped_sample());
         end
         drain();
      end
      if (sb.errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
